// ----- design/zof_pkg.sv -----
`default_nettype none

package zof_pkg;

  localparam int THRESH_W    = 12;
  localparam int THRESH_FRAC = 8;
  localparam int WCOUNT_W    = 7;
  localparam int CFG_W       = 12;
  localparam int INDEX_W     = 6;
  localparam int CHUNK_W     = 16;

  localparam logic [THRESH_W-1:0] THRESH_RESET = 12'd512;
  localparam logic [WCOUNT_W-1:0] WCOUNT_RESET = 7'd64;

  typedef enum logic {
    REG_THRESHOLD    = 1'b0,
    REG_WINDOW_COUNT = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    MUL_NQ,
    MUL_SS,
    MUL_RHS,
    MUL_DD
  } mul_sel_t;

  typedef enum logic [4:0] {
    ST_LOAD,
    ST_ACC,
    ST_NQ_GO,
    ST_NQ_RUN,
    ST_SS_GO,
    ST_SS_RUN,
    ST_DEV,
    ST_RHS_GO,
    ST_RHS_RUN,
    ST_RHS_CAP,
    ST_RD,
    ST_NX,
    ST_DIFF,
    ST_DD_GO,
    ST_DD_RUN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic     load;
    logic     accum;
    logic     mul_start;
    mul_sel_t mul_sel;
    logic     cap_nq;
    logic     cap_dev;
    logic     cap_rhs;
    logic     nx;
    logic     diff;
    logic     emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic window_full;
    logic mul_last;
    logic out_room;
    logic last_item;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- design/zof_mul.sv -----
`default_nettype none

module zof_mul import zof_pkg::*; #(
  parameter int AW = 45,
  parameter int BW = 24
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] product,
  output logic             last
);

  localparam int STEPS = (BW + CHUNK_W - 1) / CHUNK_W;
  localparam int BPW   = STEPS * CHUNK_W;
  localparam int PW    = AW + BW;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [AW-1:0]         a_reg;
  logic [BPW-1:0]        b_sh;
  logic [PW-1:0]         acc;
  logic [CNT_W-1:0]      cnt;
  logic [AW+CHUNK_W-1:0] partial;

  // one chunk of b per cycle, most significant chunk first
  assign partial = a_reg * b_sh[BPW-1 -: CHUNK_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(STEPS);
    end else if (cnt != '0) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_reg <= a;
      b_sh  <= BPW'(b);
      acc   <= '0;
    end else if (cnt != '0) begin
      acc  <= (acc << CHUNK_W) + PW'(partial);
      b_sh <= b_sh << CHUNK_W;
    end
  end

  assign product = acc;
  assign last    = (cnt == CNT_W'(1));

endmodule

`default_nettype wire

// ----- design/zof_ctrl.sv -----
`default_nettype none

module zof_ctrl import zof_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    in_ready   = 1'b0;
    state_next = state;
    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd.accum  = 1'b1;
        state_next = status.window_full ? ST_NQ_GO : ST_LOAD;
      end
      // window statistics: n*Q, then S^2, then deviation times t^2
      ST_NQ_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MUL_NQ;
        state_next    = ST_NQ_RUN;
      end
      ST_NQ_RUN: begin
        if (status.mul_last) begin
          state_next = ST_SS_GO;
        end
      end
      ST_SS_GO: begin
        cmd.cap_nq    = 1'b1;
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MUL_SS;
        state_next    = ST_SS_RUN;
      end
      ST_SS_RUN: begin
        if (status.mul_last) begin
          state_next = ST_DEV;
        end
      end
      ST_DEV: begin
        cmd.cap_dev = 1'b1;
        state_next  = ST_RHS_GO;
      end
      ST_RHS_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MUL_RHS;
        state_next    = ST_RHS_RUN;
      end
      ST_RHS_RUN: begin
        if (status.mul_last) begin
          state_next = ST_RHS_CAP;
        end
      end
      ST_RHS_CAP: begin
        cmd.cap_rhs = 1'b1;
        state_next  = ST_NX;
      end
      // per stored sample
      ST_RD: begin
        state_next = ST_NX;
      end
      ST_NX: begin
        cmd.nx     = 1'b1;
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = ST_DD_GO;
      end
      ST_DD_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = MUL_DD;
        state_next    = ST_DD_RUN;
      end
      ST_DD_RUN: begin
        if (status.mul_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.out_room) begin
          cmd.emit   = 1'b1;
          state_next = status.last_item ? ST_LOAD : ST_RD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/zof_datapath.sv -----
`default_nettype none

module zof_datapath import zof_pkg::*; #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ctrl_cmd_t                     cmd,
  output dp_status_t                    status,
  input  logic                          cfg_write,
  input  logic [0:0]                    cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [INDEX_W-1:0]            sample_index,
  output logic                          is_outlier,
  output logic                          last_of_window
);

  localparam int ADDR_W = $clog2(MAX_WINDOW);
  localparam int NW     = $clog2(MAX_WINDOW + 1);
  localparam int SW     = SAMPLE_BITS + ADDR_W;
  localparam int QW     = 2 * SAMPLE_BITS + ADDR_W;
  localparam int DW     = NW + SAMPLE_BITS;
  localparam int DEVW   = NW + QW;
  localparam int T2W    = 2 * THRESH_W;
  localparam int MA_W   = DEVW;
  localparam int MB_W   = (DW > T2W) ? DW : T2W;
  localparam int PW     = MA_W + MB_W;
  localparam int EW     = (NW > WCOUNT_W) ? NW : WCOUNT_W;
  localparam int KXW    = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;
  localparam int ZSH    = 2 * THRESH_FRAC;

  logic [THRESH_W-1:0]          threshold;
  logic [WCOUNT_W-1:0]          wcount;

  logic signed [SAMPLE_BITS-1:0] mem [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] rd_data;
  logic signed [SAMPLE_BITS-1:0] x_reg;
  logic [2*SAMPLE_BITS-1:0]      sq;

  logic signed [SW-1:0] sum;
  logic [QW-1:0]        sqsum;
  logic [NW-1:0]        fill;
  logic [ADDR_W-1:0]    k;

  logic signed [DW:0]   nx_reg;
  logic signed [DW:0]   d;
  logic [DW-1:0]        dmag;
  logic [SW-1:0]        smag;
  logic [T2W-1:0]       t2;
  logic [DEVW-1:0]      nq;
  logic [DEVW-1:0]      dev;
  logic [PW-1:0]        rhs;

  logic [MA_W-1:0]      ma;
  logic [MB_W-1:0]      mb;
  logic [PW-1:0]        product;
  logic                 mul_last;

  logic [EW-1:0]        wc_e;
  logic [EW-1:0]        max_e;
  logic [EW-1:0]        n_eff;
  logic [KXW-1:0]       kx;
  logic                 gt;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESH_RESET;
      wcount    <= WCOUNT_RESET;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_THRESHOLD:    threshold <= cfg_data[THRESH_W-1:0];
        REG_WINDOW_COUNT: wcount    <= cfg_data[WCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // sample store
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[fill[ADDR_W-1:0]] <= sample;
    end
    rd_data <= mem[k];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_reg <= sample;
      sq    <= $unsigned((2*SAMPLE_BITS)'(sample) * (2*SAMPLE_BITS)'(sample));
    end
  end

  // running statistics and window position
  always_ff @(posedge clk) begin
    if (rst) begin
      sum   <= '0;
      sqsum <= '0;
      fill  <= '0;
      k     <= '0;
    end else if (cmd.accum) begin
      sum   <= sum + SW'(x_reg);
      sqsum <= sqsum + QW'(sq);
      fill  <= fill + NW'(1);
    end else if (cmd.emit) begin
      if (status.last_item) begin
        sum   <= '0;
        sqsum <= '0;
        fill  <= '0;
        k     <= '0;
      end else begin
        k <= k + ADDR_W'(1);
      end
    end
  end

  // window length, zero counts as one, clipped to the store depth
  assign wc_e  = EW'(wcount);
  assign max_e = EW'(MAX_WINDOW);
  always_comb begin
    if (wcount == '0) begin
      n_eff = EW'(1);
    end else if (wc_e > max_e) begin
      n_eff = max_e;
    end else begin
      n_eff = wc_e;
    end
  end

  assign smag = sum[SW-1] ? $unsigned(-sum) : $unsigned(sum);
  assign t2   = T2W'(threshold) * T2W'(threshold);
  assign d    = nx_reg - (DW+1)'(sum);

  always_comb begin
    case (cmd.mul_sel)
      MUL_NQ: begin
        ma = MA_W'(sqsum);
        mb = MB_W'(fill);
      end
      MUL_SS: begin
        ma = MA_W'(smag);
        mb = MB_W'(smag);
      end
      MUL_RHS: begin
        ma = dev;
        mb = MB_W'(t2);
      end
      MUL_DD: begin
        ma = MA_W'(dmag);
        mb = MB_W'(dmag);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  zof_mul #(
    .AW (MA_W),
    .BW (MB_W)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.mul_start),
    .a       (ma),
    .b       (mb),
    .product (product),
    .last    (mul_last)
  );

  // n*Q - S^2 is never negative, so the deviation term stays unsigned
  always_ff @(posedge clk) begin
    if (cmd.cap_nq) begin
      nq <= product[DEVW-1:0];
    end
    if (cmd.cap_dev) begin
      dev <= nq - product[DEVW-1:0];
    end
    if (cmd.cap_rhs) begin
      rhs <= product;
    end
    if (cmd.nx) begin
      nx_reg <= (DW+1)'($signed({1'b0, fill})) * (DW+1)'(rd_data);
    end
    if (cmd.diff) begin
      dmag <= d[DW] ? DW'(-d) : DW'(d);
    end
  end

  assign gt = {product, {ZSH{1'b0}}} > {{ZSH{1'b0}}, rhs};
  assign kx = KXW'(k);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      sample_index   <= kx[INDEX_W-1:0];
      is_outlier     <= gt;
      last_of_window <= status.last_item;
    end
  end

  assign status.window_full = (EW'(fill) + EW'(1)) >= n_eff;
  assign status.mul_last    = mul_last;
  assign status.out_room    = !out_valid || out_ready;
  assign status.last_item   = (NW'(k) + NW'(1)) == fill;

endmodule

`default_nettype wire

// ----- design/zscore_outlier_flagger_core.sv -----
// z-score outlier flagger
// input channel (in_valid/in_ready, sample): one signed sample per request.
// samples fill a window of window_count entries (zero means one, larger than
// MAX_WINDOW means MAX_WINDOW); each request is stored in ST_LOAD and added
// into the running sum and sum of squares in ST_ACC.
// when the window is full the block emits one result per stored sample on
// the output channel (out_valid/out_ready), in load order, with last_of_window
// on the final one, then opens a fresh window. in_ready stays low meanwhile.
// cost is set by the shared chunked multiplier, STEPS = ceil(W/16) chunks per
// product with W the wider of clog2(MAX_WINDOW+1) + SAMPLE_BITS and 24 (2 at
// the defaults): window close runs three products in turn, then each result
// one product of the sample's deviation.
// a result sits in an output register; while out_ready is low the block holds
// it and waits with the next result finished in the multiplier.
// config writes (cfg_write, cfg_index, cfg_data) take effect at once and are
// meant for idle periods. reset empties the window, clears the output and
// loads threshold 2.0 and window count 64; the sample store is not cleared.
`default_nettype none

module zscore_outlier_flagger_core import zof_pkg::*; #(
  parameter int MAX_WINDOW  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [INDEX_W-1:0]            sample_index,
  output logic                          is_outlier,
  output logic                          last_of_window,
  input  logic                          cfg_write,
  input  logic [0:0]                    cfg_index,
  input  logic [CFG_W-1:0]              cfg_data
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  zof_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  zof_datapath #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .sample         (sample),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .sample_index   (sample_index),
    .is_outlier     (is_outlier),
    .last_of_window (last_of_window)
  );

endmodule

`default_nettype wire
